[sv/lsc_pkg.sv]
`default_nettype none

package lsc_pkg;

    // Width of the capacity register and its value after reset.
    localparam int unsigned CapWidth = 4;
    localparam logic [CapWidth-1:0] CapReset = 4'd8;

    // Shifted digit symbols and the digits they stand for.
    localparam logic [7:0] SymExcl   = 8'h21; // '!'
    localparam logic [7:0] SymAt     = 8'h40; // '@'
    localparam logic [7:0] SymHash   = 8'h23; // '#'
    localparam logic [7:0] SymDollar = 8'h24; // '$'
    localparam logic [7:0] SymPct    = 8'h25; // '%'
    localparam logic [7:0] SymCaret  = 8'h5E; // '^'
    localparam logic [7:0] SymAmp    = 8'h26; // '&'
    localparam logic [7:0] SymStar   = 8'h2A; // '*'
    localparam logic [7:0] SymLParen = 8'h28; // '('
    localparam logic [7:0] SymRParen = 8'h29; // ')'
    localparam logic [7:0] DigitZero = 8'h30; // '0'

    // One cached pair.
    typedef struct packed {
        logic [7:0] key;
        logic [7:0] value;
    } entry_t;

    // Per-cell control from the top level.
    typedef struct packed {
        logic valid;      // cell holds a live entry
        logic load_head;  // cell takes the new most recently used entry
        logic take_prev;  // cell takes its neighbor's entry (ages by one)
    } cell_ctrl_t;

    // Result of the symbol lookup.
    typedef struct packed {
        logic       found;
        logic [7:0] digit;
    } sym_t;

    // Maps a shifted digit symbol to its digit character.
    function automatic sym_t sym_map(input logic [7:0] c);
        sym_t r;
        r.found = 1'b1;
        r.digit = DigitZero;
        case (c)
            SymExcl:   r.digit = DigitZero + 8'd1;
            SymAt:     r.digit = DigitZero + 8'd2;
            SymHash:   r.digit = DigitZero + 8'd3;
            SymDollar: r.digit = DigitZero + 8'd4;
            SymPct:    r.digit = DigitZero + 8'd5;
            SymCaret:  r.digit = DigitZero + 8'd6;
            SymAmp:    r.digit = DigitZero + 8'd7;
            SymStar:   r.digit = DigitZero + 8'd8;
            SymLParen: r.digit = DigitZero + 8'd9;
            SymRParen: r.digit = DigitZero;
            default:   r.found = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/lsc_cell.sv]
`default_nettype none

module lsc_cell (
    input  wire logic               aclk,
    input  wire lsc_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]         lookup_key,
    input  wire lsc_pkg::entry_t    head_entry,
    input  wire lsc_pkg::entry_t    prev_entry,
    output lsc_pkg::entry_t         entry,
    output logic                    match
);

    lsc_pkg::entry_t entry_reg;
    lsc_pkg::entry_t entry_next;

    // A live entry matches when its key equals the looked-up byte.
    assign match = ctrl.valid && (entry_reg.key == lookup_key);
    assign entry = entry_reg;

    // The head cell loads the new entry; other cells shift from their neighbor.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.load_head) begin
            entry_next = head_entry;
        end else if (ctrl.take_prev) begin
            entry_next = prev_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

[sv/lru_symbol_cache_core.sv]
`default_nettype none

// Fully associative symbol cache with true least-recently-used replacement.
// Entries sit in a row of cells ordered by recency: cell 0 holds the most
// recently used entry and live entries always fill cells 0 to count-1, so the
// least recently used one is the last live cell. A hit moves the matching
// entry to cell 0 and shifts the younger cells down by one; an insert shifts
// the live cells down and drops the last one when the cache is at capacity.
// The block takes one transaction per clock cycle: all cells compare the key
// in the cycle of acceptance and the result is held in an output register, so
// s_ready is high whenever that register is empty or being emptied. The user
// must write the cache_capacity register (cfg_data) only while the block is
// idle, unchecked by the block; 0 acts as 1, above CACHE_DEPTH as CACHE_DEPTH.
module lru_symbol_cache_core #(
    parameter int unsigned CACHE_DEPTH = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lsc_pkg::CapWidth-1:0]  cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_key_char,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_out_char,
    output logic                               m_hit,
    output logic                               m_evicted,
    output logic [7:0]                         m_evicted_key
);

    localparam int unsigned CntW = $clog2(CACHE_DEPTH + 1);
    localparam int unsigned IdxW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int unsigned CmpW = (CntW > lsc_pkg::CapWidth) ? CntW : lsc_pkg::CapWidth;

    logic [lsc_pkg::CapWidth-1:0] cap_reg;
    logic [CntW-1:0]              occ_reg;
    logic [CntW-1:0]              occ_next;

    logic                         m_valid_reg;
    logic [7:0]                   out_char_reg;
    logic                         hit_reg;
    logic                         evicted_reg;
    logic [7:0]                   evicted_key_reg;

    lsc_pkg::entry_t    cell_entry [CACHE_DEPTH];
    lsc_pkg::cell_ctrl_t cell_ctrl [CACHE_DEPTH];
    logic [CACHE_DEPTH-1:0] cell_match;

    logic            accept;
    logic            hit_any;
    logic [IdxW-1:0] hit_pos;
    logic [7:0]      hit_value;
    logic [7:0]      tail_key;
    lsc_pkg::sym_t   sym;
    logic            insert;
    logic            full;
    logic            evict;
    logic            update;
    logic [CntW-1:0] shift_limit;
    logic [CmpW-1:0] eff_cap;
    lsc_pkg::entry_t head_entry;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    // Capacity register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lsc_pkg::CapReset;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    // Clamp the capacity into 1 .. CACHE_DEPTH.
    always_comb begin
        eff_cap = CmpW'(cap_reg);
        if (cap_reg == '0) begin
            eff_cap = CmpW'(1);
        end else if (CmpW'(cap_reg) > CmpW'(CACHE_DEPTH)) begin
            eff_cap = CmpW'(CACHE_DEPTH);
        end
    end

    // Gather the hit position, hit value and the least recently used key.
    always_comb begin
        hit_pos   = '0;
        hit_value = '0;
        tail_key  = '0;
        for (int i = 0; i < int'(CACHE_DEPTH); i++) begin
            if (cell_match[i]) begin
                hit_pos   = hit_pos | IdxW'(i);
                hit_value = hit_value | cell_entry[i].value;
            end
            if (occ_reg == CntW'(i + 1)) begin
                tail_key = tail_key | cell_entry[i].key;
            end
        end
    end

    // Decide between hit, insert with or without eviction, and pass-through.
    always_comb begin
        hit_any = |cell_match;
        sym     = lsc_pkg::sym_map(s_key_char);
        insert  = !hit_any && sym.found;
        full    = CmpW'(occ_reg) >= eff_cap;
        evict   = insert && full;
        update  = accept && (hit_any || insert);

        if (hit_any) begin
            shift_limit = CntW'(hit_pos);
        end else if (full) begin
            shift_limit = occ_reg - CntW'(1);
        end else begin
            shift_limit = occ_reg;
        end

        occ_next = occ_reg;
        if (accept && insert && !full) begin
            occ_next = occ_reg + CntW'(1);
        end

        head_entry.key   = s_key_char;
        head_entry.value = hit_any ? hit_value : sym.digit;
    end

    // Row of recency-ordered cells.
    for (genvar g = 0; g < CACHE_DEPTH; g++) begin : g_cell
        always_comb begin
            cell_ctrl[g].valid     = CntW'(g) < occ_reg;
            cell_ctrl[g].load_head = update && (g == 0);
            cell_ctrl[g].take_prev = update && (g != 0) && (CntW'(g) <= shift_limit);
        end

        lsc_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[g]),
            .lookup_key (s_key_char),
            .head_entry (head_entry),
            .prev_entry (cell_entry[(g == 0) ? 0 : g - 1]),
            .entry      (cell_entry[g]),
            .match      (cell_match[g])
        );
    end

    // Occupancy count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // Output register; it frees up as soon as the result transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (hit_any) begin
                out_char_reg <= hit_value;
            end else if (sym.found) begin
                out_char_reg <= sym.digit;
            end else begin
                out_char_reg <= s_key_char;
            end
            hit_reg         <= hit_any;
            evicted_reg     <= evict;
            evicted_key_reg <= evict ? tail_key : 8'd0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_char    = out_char_reg;
    assign m_hit         = hit_reg;
    assign m_evicted     = evicted_reg;
    assign m_evicted_key = evicted_key_reg;

endmodule

`default_nettype wire
